FILE: rtl/keyframe_table_interpolator_macros.svh
// Assertion macros for the keyframe table interpolator RTL.
`ifndef KEYFRAME_TABLE_INTERPOLATOR_MACROS_SVH
`define KEYFRAME_TABLE_INTERPOLATOR_MACROS_SVH
`ifndef NO_ASSERTIONS
`define KTI_ASSERT(label, clk, rst_n, prop) \
	label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error("%m failed");
`define KTI_ASSERT_NEVER(label, clk, rst_n, expr) \
	label: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) else $error("%m failed");
`else
`define KTI_ASSERT(label, clk, rst_n, prop)
`define KTI_ASSERT_NEVER(label, clk, rst_n, expr)
`endif
`endif

FILE: rtl/kti_pkg.sv
// Package with shared types and constants of the keyframe table interpolator.
`timescale 1ns / 1ps
package kti_pkg;
	localparam int KEY_CAPACITY_DEF  = 256;
	localparam int ELEMENT_COUNT_DEF = 64;
	localparam int ELEM_W = 6;
	localparam int VAL_W  = 16;
	localparam int FRAC_W = 16;

	typedef enum logic [1:0] {
		ACT_ADD    = 2'd0,
		ACT_DELETE = 2'd1,
		ACT_QUERY  = 2'd2,
		ACT_NOP    = 2'd3
	} action_t;

	typedef enum logic [1:0] {
		ST_DONE      = 2'd0,
		ST_FULL      = 2'd1,
		ST_NOT_FOUND = 2'd2,
		ST_NONE      = 2'd3
	} status_t;

	typedef struct packed {
		logic [1:0]              action;
		logic [ELEM_W-1:0]       element;
		logic [15:0]             frame_time;
		logic signed [VAL_W-1:0] in_x;
		logic signed [VAL_W-1:0] in_y;
		logic signed [VAL_W-1:0] in_angle;
		logic signed [VAL_W-1:0] in_scale;
	} in_word_t;

	typedef struct packed {
		logic [1:0]              status;
		logic signed [VAL_W-1:0] out_x;
		logic signed [VAL_W-1:0] out_y;
		logic signed [VAL_W-1:0] out_angle;
		logic signed [VAL_W-1:0] out_scale;
		logic [FRAC_W-1:0]       mix_fraction;
	} out_word_t;

	// Item handed from the front end to the back end, with its class.
	typedef struct packed {
		in_word_t word;
		logic     elem_ok;
	} cmd_t;

	typedef struct packed {
		logic [VAL_W-1:0] x;
		logic [VAL_W-1:0] y;
		logic [VAL_W-1:0] angle;
		logic [VAL_W-1:0] scale;
	} vals_t;

	// One value blended: (b*mix + a*(65536-mix)) >>> 16, i.e. a + ((b-a)*mix >>> 16).
	function automatic logic [VAL_W-1:0] lerp16(input logic [VAL_W-1:0] a,
			input logic [VAL_W-1:0] b, input logic [FRAC_W-1:0] mix);
		logic signed [VAL_W:0]          diff;
		logic signed [VAL_W+FRAC_W+1:0] prod;
		logic signed [VAL_W+FRAC_W+1:0] sum;
		diff = $signed({b[VAL_W-1], b}) - $signed({a[VAL_W-1], a});
		prod = diff * $signed({1'b0, mix});
		sum  = prod + $signed({{(FRAC_W+2){a[VAL_W-1]}}, a} <<< FRAC_W);
		return sum[FRAC_W +: VAL_W];
	endfunction
endpackage

FILE: rtl/kti_front.sv
// Front end: accepts input words, classifies them and queues them for the back end.
`timescale 1ns / 1ps
module kti_front
	import kti_pkg::*;
#(
	parameter int ELEMENT_COUNT = ELEMENT_COUNT_DEF
) (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     in_valid,
	output logic     in_ready,
	input  in_word_t in_word,
	output logic     cmd_valid,
	input  logic     cmd_ready,
	output cmd_t     cmd
);
	// Two-entry queue.
	cmd_t       fifo_q [2];
	logic       wr_ptr_q, rd_ptr_q;
	logic [1:0] cnt_q;
	logic       push, pop;
	cmd_t       cls;

	always_comb begin
		cls.word    = in_word;
		cls.elem_ok = ({3'b0, in_word.element} < 9'(ELEMENT_COUNT));
	end

	assign in_ready  = (cnt_q != 2'd2);
	assign cmd_valid = (cnt_q != 2'd0);
	assign cmd       = fifo_q[rd_ptr_q];
	assign push      = in_valid && in_ready;
	assign pop       = cmd_valid && cmd_ready;

	always_ff @(posedge clk) begin
		if (push) begin
			fifo_q[wr_ptr_q] <= cls;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			cnt_q    <= 2'd0;
		end else begin
			if (push) begin
				wr_ptr_q <= ~wr_ptr_q;
			end
			if (pop) begin
				rd_ptr_q <= ~rd_ptr_q;
			end
			cnt_q <= cnt_q + {1'b0, push} - {1'b0, pop};
		end
	end
endmodule

FILE: rtl/kti_div.sv
// Serial restoring divider giving the 16-bit interpolation fraction.
`timescale 1ns / 1ps
module kti_div
	import kti_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	input  logic [15:0]       num,
	input  logic [15:0]       den,
	output logic              busy,
	output logic [FRAC_W-1:0] quo
);
	// Dividend num<<16, 16 quotient bits are needed since num < den.
	logic [16:0] rem_q;
	logic [15:0] den_q;
	logic [4:0]  cnt_q;
	logic [17:0] trial;

	assign busy  = (cnt_q != 5'd0);
	assign trial = {rem_q, 1'b0} - {2'b0, den_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= 5'd0;
		end else if (start) begin
			cnt_q <= 5'd16;
		end else if (busy) begin
			cnt_q <= cnt_q - 5'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= {1'b0, num};
			den_q <= den;
		end else if (busy) begin
			if (!trial[17]) begin
				rem_q <= trial[16:0];
				quo   <= {quo[14:0], 1'b1};
			end else begin
				rem_q <= {rem_q[15:0], 1'b0};
				quo   <= {quo[14:0], 1'b0};
			end
		end
	end
endmodule

FILE: rtl/kti_back.sv
// Back end: keyframe table memory, scan sequencer, compaction and blending.
`timescale 1ns / 1ps
`include "keyframe_table_interpolator_macros.svh"
module kti_back
	import kti_pkg::*;
#(
	parameter int KEY_CAPACITY = KEY_CAPACITY_DEF
) (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      cmd_valid,
	output logic      cmd_ready,
	input  cmd_t      cmd,
	output logic      out_valid,
	input  logic      out_ready,
	output out_word_t out_word
);
	localparam int AW = $clog2(KEY_CAPACITY);
	localparam int CW = AW + 1;

	typedef struct packed {
		logic [ELEM_W-1:0] elem;
		logic [15:0]       t;
		vals_t             v;
	} entry_t;

	typedef enum logic [3:0] {
		S_IDLE, S_SCAN, S_SCAN_LAST, S_DECIDE, S_SHIFT_RD, S_SHIFT_WR,
		S_DIV, S_FETCH_LO, S_FETCH_HI, S_BLEND, S_OUT
	} state_t;

	entry_t mem_q [KEY_CAPACITY];
	entry_t rd_q;
	logic [AW-1:0] rd_addr;
	logic          wr_en;
	logic [AW-1:0] wr_addr;
	entry_t        wr_data;

	state_t        state_q;
	cmd_t          cur_q;
	logic [CW-1:0] count_q;
	logic [CW-1:0] idx_q;      // next address issued
	logic [CW-1:0] chk_q;      // address of the word now in rd_q
	logic          found_q, lo_ok_q, hi_ok_q;
	logic [AW-1:0] found_idx_q, lo_idx_q, hi_idx_q;
	logic [15:0]   lo_t_q, hi_t_q;
	vals_t         lo_v_q;
	out_word_t     res_q;
	logic          div_start, div_busy;
	logic [15:0]   div_quo;
	logic          match;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		rd_q <= mem_q[rd_addr];
	end

	kti_div u_div (
		.clk(clk), .arst_n(arst_n), .start(div_start),
		.num(cur_q.word.frame_time - lo_t_q), .den(hi_t_q - lo_t_q),
		.busy(div_busy), .quo(div_quo)
	);

	assign match = (rd_q.elem == cur_q.word.element);

	always_comb begin
		rd_addr   = idx_q[AW-1:0];
		wr_en     = 1'b0;
		wr_addr   = idx_q[AW-1:0];
		wr_data   = rd_q;
		div_start = (state_q == S_DECIDE) && lo_ok_q && hi_ok_q
			&& (cur_q.word.action == ACT_QUERY) && cur_q.elem_ok;
		// While idle, entry 0 is kept in rd_q so a scan can start at once.
		if (state_q == S_IDLE) rd_addr = '0;
		if (state_q == S_FETCH_LO) rd_addr = lo_idx_q;
		if (state_q == S_FETCH_HI) rd_addr = hi_idx_q;
		if (state_q == S_SHIFT_WR) begin
			wr_en   = 1'b1;
			wr_addr = AW'(chk_q - CW'(1));
		end
		if (state_q == S_DECIDE && cur_q.word.action == ACT_ADD
				&& (found_q || count_q != CW'(KEY_CAPACITY))) begin
			wr_en   = 1'b1;
			wr_addr = found_q ? found_idx_q : count_q[AW-1:0];
			wr_data = '{elem: cur_q.word.element, t: cur_q.word.frame_time,
				v: '{x: cur_q.word.in_x, y: cur_q.word.in_y,
				angle: cur_q.word.in_angle, scale: cur_q.word.in_scale}};
		end
	end

	assign cmd_ready = (state_q == S_IDLE);
	assign out_valid = (state_q == S_OUT);
	assign out_word  = res_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			count_q <= '0;
			idx_q   <= '0;
			chk_q   <= '0;
			found_q <= 1'b0;
			lo_ok_q <= 1'b0;
			hi_ok_q <= 1'b0;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (cmd_valid) begin
						cur_q   <= cmd;
						idx_q   <= '0;
						chk_q   <= '0;
						found_q <= 1'b0;
						lo_ok_q <= 1'b0;
						hi_ok_q <= 1'b0;
						res_q   <= '0;
						if (count_q == '0) begin
							state_q <= S_DECIDE;
						end else begin
							idx_q   <= CW'(1);
							state_q <= S_SCAN;
						end
					end
				end
				S_SCAN, S_SCAN_LAST: begin
					// rd_q holds entry chk_q
					if (match && rd_q.t == cur_q.word.frame_time && !found_q) begin
						found_q     <= 1'b1;
						found_idx_q <= chk_q[AW-1:0];
					end
					if (match && rd_q.t <= cur_q.word.frame_time) begin
						if (!lo_ok_q || lo_t_q <= rd_q.t) begin
							lo_ok_q <= 1'b1; lo_t_q <= rd_q.t; lo_idx_q <= chk_q[AW-1:0];
						end
					end else if (match) begin
						if (!hi_ok_q || hi_t_q > rd_q.t) begin
							hi_ok_q <= 1'b1; hi_t_q <= rd_q.t; hi_idx_q <= chk_q[AW-1:0];
						end
					end
					chk_q <= chk_q + CW'(1);
					if (chk_q + CW'(1) == count_q) begin
						state_q <= S_DECIDE;
					end else begin
						idx_q <= idx_q + CW'(1);
					end
				end
				S_DECIDE: begin
					priority case (cur_q.word.action)
						ACT_ADD: begin
							if (!found_q && count_q == CW'(KEY_CAPACITY)) begin
								res_q.status <= ST_FULL;
							end else if (!found_q) begin
								count_q <= count_q + CW'(1);
							end
							state_q <= S_OUT;
						end
						ACT_DELETE: begin
							if (!found_q) begin
								res_q.status <= ST_NOT_FOUND;
								state_q <= S_OUT;
							end else begin
								count_q <= count_q - CW'(1);
								chk_q   <= {1'b0, found_idx_q} + CW'(1);
								idx_q   <= {1'b0, found_idx_q} + CW'(1);
								state_q <= S_SHIFT_RD;
							end
						end
						ACT_QUERY: begin
							if (!cur_q.elem_ok || (!lo_ok_q && !hi_ok_q)) begin
								res_q.status <= ST_NONE;
								state_q <= S_OUT;
							end else if (lo_ok_q && hi_ok_q) begin
								state_q <= S_DIV;
							end else begin
								if (!lo_ok_q) lo_idx_q <= hi_idx_q;
								if (!hi_ok_q) hi_idx_q <= lo_idx_q;
								state_q <= S_FETCH_LO;
							end
						end
						default: state_q <= S_OUT;
					endcase
				end
				S_SHIFT_RD: begin
					// count_q already decremented; move entry chk_q down while chk_q <= count
					if (chk_q > count_q) begin
						state_q <= S_OUT;
					end else begin
						state_q <= S_SHIFT_WR;
					end
				end
				S_SHIFT_WR: begin
					chk_q   <= chk_q + CW'(1);
					idx_q   <= idx_q + CW'(1);
					state_q <= S_SHIFT_RD;
				end
				S_DIV: begin
					if (!div_busy && !div_start) begin
						res_q.mix_fraction <= div_quo;
						state_q <= S_FETCH_LO;
					end
				end
				S_FETCH_LO: state_q <= S_FETCH_HI;
				S_FETCH_HI: begin
					lo_v_q  <= rd_q.v;
					state_q <= S_BLEND;
				end
				S_BLEND: begin
					res_q.out_x     <= lerp16(lo_v_q.x, rd_q.v.x, res_q.mix_fraction);
					res_q.out_y     <= lerp16(lo_v_q.y, rd_q.v.y, res_q.mix_fraction);
					res_q.out_angle <= lerp16(lo_v_q.angle, rd_q.v.angle, res_q.mix_fraction);
					res_q.out_scale <= lerp16(lo_v_q.scale, rd_q.v.scale, res_q.mix_fraction);
					state_q <= S_OUT;
				end
				S_OUT: begin
					if (out_ready) state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	`KTI_ASSERT(a_count_range, clk, arst_n, count_q <= CW'(KEY_CAPACITY))
	`KTI_ASSERT(a_out_hold, clk, arst_n, out_valid && !out_ready |=> out_valid && $stable(out_word))
	`KTI_ASSERT_NEVER(a_busy_ready, clk, arst_n, cmd_ready && out_valid)
endmodule

FILE: rtl/keyframe_table_interpolator.sv
// Top level of the keyframe table interpolator.
// With n stored keyframes, the work per word is set by one scan of the table memory;
// a delete adds a pass that shifts later entries down, and a two-sided query
// adds a 16-step serial divider before the two fetches and the blend.
// Throughput: one word at a time in the back end; the front queue holds two.
// Reset: arst_n clears the keyframe count and all control; table contents
// are left as they are and never used beyond the count.
`timescale 1ns / 1ps
module keyframe_table_interpolator
	import kti_pkg::*;
#(
	parameter int KEY_CAPACITY  = KEY_CAPACITY_DEF,
	parameter int ELEMENT_COUNT = ELEMENT_COUNT_DEF
) (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      in_valid,
	output logic      in_ready,
	input  in_word_t  in_word,
	output logic      out_valid,
	input  logic      out_ready,
	output out_word_t out_word
);
	// The front end queues classified words so the back end can stall on its own.
	logic cmd_valid, cmd_ready;
	cmd_t cmd;

	kti_front #(.ELEMENT_COUNT(ELEMENT_COUNT)) u_front (
		.clk(clk), .arst_n(arst_n), .in_valid(in_valid), .in_ready(in_ready),
		.in_word(in_word), .cmd_valid(cmd_valid), .cmd_ready(cmd_ready), .cmd(cmd)
	);

	// The back end scans the table, updates it and forms the result word.
	kti_back #(.KEY_CAPACITY(KEY_CAPACITY)) u_back (
		.clk(clk), .arst_n(arst_n), .cmd_valid(cmd_valid), .cmd_ready(cmd_ready),
		.cmd(cmd), .out_valid(out_valid), .out_ready(out_ready), .out_word(out_word)
	);
endmodule
